>>> rtl/lwm_pkg.sv
// Shared constants, command codes and queue item types for the latency window monitor.
package lwm_pkg;

  localparam int WINDOW_DEPTH  = 64;
  localparam int PENDING_DEPTH = 16;
  localparam int QUEUE_DEPTH   = 4;

  localparam int CMD_W = 2;
  localparam int TS_W  = 16;
  localparam int LAT_W = 16;
  localparam int CNT_W = 16;
  localparam int TOT_W = 32;

  localparam int WIN_AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = LAT_W + $clog2(WINDOW_DEPTH);
  localparam int PEND_AW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CW = $clog2(PENDING_DEPTH + 1);
  localparam int QUEUE_AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND = 2'd0,
    CMD_ACK  = 2'd1,
    CMD_DISC = 2'd2
  } cmd_t;

  // Classified item handed from front to back
  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [LAT_W-1:0] lat;
    logic             lat_valid;
    logic             ovf;
  } q_item_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

>>> rtl/lwm_ram.sv
// Generic simple dual-port RAM with registered read.
module lwm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/lwm_div.sv
// Restoring divider, one quotient bit per cycle, quotient saturated to 16 bits.
module lwm_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [lwm_pkg::SUM_W-1:0] dividend,
  input  logic [lwm_pkg::CNT_W-1:0] divisor,
  output logic                      done,
  output logic [lwm_pkg::LAT_W-1:0] quot
);
  import lwm_pkg::*;

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [CNT_W-1:0]  rem_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  dvs_r;
  logic [CNT_W:0]    rem_sh;
  logic [CNT_W:0]    diff;
  logic              ge;

  assign rem_sh = {rem_r, quo_r[SUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_r};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= STEP_W'(SUM_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], ge};
        step_r <= step_r - STEP_W'(1);
        if (step_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = (|quo_r[SUM_W-1:LAT_W]) ? '1 : quo_r[LAT_W-1:0];

endmodule

>>> rtl/lwm_front.sv
// Front end: accepts events, keeps the pending request FIFO, measures latency.
module lwm_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lwm_pkg::CMD_W-1:0] in_cmd,
  input  logic [lwm_pkg::TS_W-1:0]  in_now_ms,
  input  lwm_pkg::q_stat_t          q_stat,
  output logic                      q_push,
  output lwm_pkg::q_item_t          q_item
);
  import lwm_pkg::*;

  typedef enum logic [1:0] {
    F_IDLE = 2'b01,
    F_POP  = 2'b10
  } f_state_t;

  localparam logic [PEND_AW:0] PEND_LIM = (PEND_AW + 1)'(PENDING_DEPTH);

  f_state_t           f_state_r, f_state_nxt;
  logic [PEND_AW-1:0] p_head_r, p_head_nxt;
  logic [PEND_CW-1:0] p_count_r, p_count_nxt;
  logic [TS_W-1:0]    now_r;

  logic               accept;
  logic               p_full;
  logic [PEND_AW:0]   tail_sum;
  logic [PEND_AW:0]   tail_wrap;
  logic [PEND_AW-1:0] head_inc;
  logic               pw_en;
  logic [TS_W-1:0]    p_rdata;

  assign in_stall = !((f_state_r == F_IDLE) && !q_stat.full);
  assign accept   = in_valid && !in_stall;
  assign p_full   = p_count_r == PEND_CW'(PENDING_DEPTH);

  assign tail_sum  = {1'b0, p_head_r} + (PEND_AW + 1)'(p_count_r);
  assign tail_wrap = (tail_sum >= PEND_LIM) ? tail_sum - PEND_LIM : tail_sum;
  assign head_inc  = (p_head_r == PEND_AW'(PENDING_DEPTH - 1)) ? '0 : p_head_r + PEND_AW'(1);

  // Read port always sits on the oldest entry; data is ready in F_POP
  lwm_ram #(.WIDTH(TS_W), .DEPTH(PENDING_DEPTH)) u_pend_ram (
    .clk   (clk),
    .we    (pw_en),
    .waddr (tail_wrap[PEND_AW-1:0]),
    .wdata (in_now_ms),
    .raddr (p_head_r),
    .rdata (p_rdata)
  );

  always_comb begin
    f_state_nxt      = f_state_r;
    p_head_nxt       = p_head_r;
    p_count_nxt      = p_count_r;
    pw_en            = 1'b0;
    q_push           = 1'b0;
    q_item.cmd       = in_cmd;
    q_item.lat       = '0;
    q_item.lat_valid = 1'b0;
    q_item.ovf       = 1'b0;
    unique case (f_state_r)
      F_IDLE: begin
        if (accept) begin
          unique case (in_cmd)
            CMD_SEND: begin
              if (!p_full) begin
                pw_en       = 1'b1;
                p_count_nxt = p_count_r + PEND_CW'(1);
              end else begin
                q_item.ovf = 1'b1;
              end
              q_push = 1'b1;
            end
            CMD_ACK: begin
              if (p_count_r != '0) begin
                f_state_nxt = F_POP;
              end else begin
                q_push = 1'b1;
              end
            end
            CMD_DISC: begin
              p_head_nxt  = '0;
              p_count_nxt = '0;
              q_push      = 1'b1;
            end
            default: begin
              q_push = 1'b1;
            end
          endcase
        end
      end
      F_POP: begin
        q_item.cmd       = CMD_ACK;
        q_item.lat       = now_r - p_rdata;
        q_item.lat_valid = 1'b1;
        q_push           = 1'b1;
        p_head_nxt       = head_inc;
        p_count_nxt      = p_count_r - PEND_CW'(1);
        f_state_nxt      = F_IDLE;
      end
      default: begin
        f_state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_state_r <= F_IDLE;
      p_head_r  <= '0;
      p_count_r <= '0;
    end else begin
      f_state_r <= f_state_nxt;
      p_head_r  <= p_head_nxt;
      p_count_r <= p_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now_ms;
    end
  end

endmodule

>>> rtl/lwm_queue.sv
// Short FIFO of classified items between front and back.
module lwm_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lwm_pkg::q_item_t push_item,
  input  logic             pop,
  output lwm_pkg::q_item_t pop_item,
  output lwm_pkg::q_stat_t q_stat
);
  import lwm_pkg::*;

  q_item_t             slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_CW-1:0] cnt_r;

  function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
    return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + QUEUE_CW'(1);
        2'b01:   cnt_r <= cnt_r - QUEUE_CW'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign pop_item     = slots[rd_ptr_r];
  assign q_stat.empty = cnt_r == '0;
  assign q_stat.full  = cnt_r == QUEUE_CW'(QUEUE_DEPTH);

endmodule

>>> rtl/lwm_back.sv
// Back end: counters, sliding window with sum and peak, average, result register.
module lwm_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lwm_pkg::q_stat_t          q_stat,
  input  lwm_pkg::q_item_t          q_item,
  output logic                      q_pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lwm_pkg::LAT_W-1:0] out_latency,
  output logic                      out_latency_valid,
  output logic [lwm_pkg::LAT_W-1:0] out_average_latency,
  output logic [lwm_pkg::LAT_W-1:0] out_max_latency,
  output logic [lwm_pkg::CNT_W-1:0] out_window_samples,
  output logic [lwm_pkg::TOT_W-1:0] out_total_acks,
  output logic                      out_queue_overflow
);
  import lwm_pkg::*;

  typedef enum logic [5:0] {
    B_IDLE   = 6'b000001,
    B_EVICT  = 6'b000010,
    B_SCAN   = 6'b000100,
    B_DSTART = 6'b001000,
    B_DWAIT  = 6'b010000,
    B_OUT    = 6'b100000
  } b_state_t;

  localparam logic [WIN_AW:0] WIN_LIM = (WIN_AW + 1)'(WINDOW_DEPTH);

  b_state_t          b_state_r, b_state_nxt;
  q_item_t           item_r, item_nxt;
  logic [WIN_AW-1:0] win_head_r, win_head_nxt;
  logic [FILL_W-1:0] win_fill_r, win_fill_nxt;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [LAT_W-1:0]  peak_r, peak_nxt;
  logic [CNT_W-1:0]  scnt_r, scnt_nxt;
  logic [TOT_W-1:0]  total_r, total_nxt;
  logic [LAT_W-1:0]  avg_r, avg_nxt;
  logic [FILL_W-1:0] scan_idx_r, scan_idx_nxt;
  logic              scan_dv_r, scan_dv_nxt;
  logic [LAT_W-1:0]  scan_max_r, scan_max_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_load;
  logic [LAT_W-1:0]  out_lat_r;
  logic              out_lat_valid_r;
  logic [LAT_W-1:0]  out_avg_r;
  logic [LAT_W-1:0]  out_max_r;
  logic [CNT_W-1:0]  out_scnt_r;
  logic [TOT_W-1:0]  out_total_r;
  logic              out_ovf_r;

  logic              w_we;
  logic [WIN_AW-1:0] w_waddr;
  logic [LAT_W-1:0]  w_wdata;
  logic [WIN_AW-1:0] w_raddr;
  logic [LAT_W-1:0]  w_rdata;

  logic              win_full;
  logic [WIN_AW:0]   tail_sum;
  logic [WIN_AW:0]   tail_wrap;
  logic [WIN_AW-1:0] head_inc;
  logic [LAT_W-1:0]  peak_evict;
  logic              scan_issue;

  logic              div_start;
  logic              div_done;
  logic [LAT_W-1:0]  div_quot;

  assign win_full   = win_fill_r == FILL_W'(WINDOW_DEPTH);
  assign tail_sum   = {1'b0, win_head_r} + (WIN_AW + 1)'(win_fill_r);
  assign tail_wrap  = (tail_sum >= WIN_LIM) ? tail_sum - WIN_LIM : tail_sum;
  assign head_inc   = (win_head_r == WIN_AW'(WINDOW_DEPTH - 1)) ? '0 : win_head_r + WIN_AW'(1);
  assign peak_evict = (item_r.lat > peak_r) ? item_r.lat : peak_r;
  assign scan_issue = scan_idx_r < FILL_W'(WINDOW_DEPTH);

  lwm_ram #(.WIDTH(LAT_W), .DEPTH(WINDOW_DEPTH)) u_win_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (w_wdata),
    .raddr (w_raddr),
    .rdata (w_rdata)
  );

  lwm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (scnt_r),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    b_state_nxt  = b_state_r;
    item_nxt     = item_r;
    win_head_nxt = win_head_r;
    win_fill_nxt = win_fill_r;
    sum_nxt      = sum_r;
    peak_nxt     = peak_r;
    scnt_nxt     = scnt_r;
    total_nxt    = total_r;
    avg_nxt      = avg_r;
    scan_idx_nxt = scan_idx_r;
    scan_dv_nxt  = scan_dv_r;
    scan_max_nxt = scan_max_r;
    q_pop        = 1'b0;
    w_we         = 1'b0;
    w_waddr      = win_head_r;
    w_wdata      = item_r.lat;
    w_raddr      = win_head_r;
    div_start    = 1'b0;
    out_load     = 1'b0;
    unique case (b_state_r)
      B_IDLE: begin
        if (!q_stat.empty) begin
          q_pop    = 1'b1;
          item_nxt = q_item;
          if (q_item.cmd == CMD_ACK) begin
            if (scnt_r != '1) begin
              scnt_nxt = scnt_r + CNT_W'(1);
            end
            if (total_r != '1) begin
              total_nxt = total_r + TOT_W'(1);
            end
            if (q_item.lat_valid && win_full) begin
              // oldest entry is read now, evicted next cycle
              b_state_nxt = B_EVICT;
            end else if (q_item.lat_valid) begin
              w_we         = 1'b1;
              w_waddr      = tail_wrap[WIN_AW-1:0];
              w_wdata      = q_item.lat;
              win_fill_nxt = win_fill_r + FILL_W'(1);
              sum_nxt      = sum_r + SUM_W'(q_item.lat);
              if (q_item.lat > peak_r) begin
                peak_nxt = q_item.lat;
              end
              b_state_nxt = B_DSTART;
            end else begin
              b_state_nxt = B_DSTART;
            end
          end else begin
            b_state_nxt = B_OUT;
          end
        end
      end
      B_EVICT: begin
        w_we         = 1'b1;
        w_waddr      = win_head_r;
        w_wdata      = item_r.lat;
        win_head_nxt = head_inc;
        sum_nxt      = sum_r - SUM_W'(w_rdata) + SUM_W'(item_r.lat);
        if (scnt_r != '0) begin
          scnt_nxt = scnt_r - CNT_W'(1);
        end
        peak_nxt = peak_evict;
        if (w_rdata == peak_evict) begin
          scan_idx_nxt = '0;
          scan_dv_nxt  = 1'b0;
          scan_max_nxt = '0;
          b_state_nxt  = B_SCAN;
        end else begin
          b_state_nxt = B_DSTART;
        end
      end
      B_SCAN: begin
        // one address issued per cycle, data folded in the next cycle
        w_raddr     = scan_idx_r[WIN_AW-1:0];
        scan_dv_nxt = scan_issue;
        if (scan_issue) begin
          scan_idx_nxt = scan_idx_r + FILL_W'(1);
        end
        if (scan_dv_r && (w_rdata > scan_max_r)) begin
          scan_max_nxt = w_rdata;
        end
        if (!scan_issue && !scan_dv_r) begin
          peak_nxt    = scan_max_r;
          b_state_nxt = B_DSTART;
        end
      end
      B_DSTART: begin
        if (scnt_r == '0) begin
          avg_nxt     = '0;
          b_state_nxt = B_OUT;
        end else begin
          div_start   = 1'b1;
          b_state_nxt = B_DWAIT;
        end
      end
      B_DWAIT: begin
        if (div_done) begin
          avg_nxt     = div_quot;
          b_state_nxt = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load    = 1'b1;
          b_state_nxt = B_IDLE;
        end
      end
      default: begin
        b_state_nxt = B_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_state_r   <= B_IDLE;
      win_head_r  <= '0;
      win_fill_r  <= '0;
      sum_r       <= '0;
      peak_r      <= '0;
      scnt_r      <= '0;
      total_r     <= '0;
      avg_r       <= '0;
      scan_idx_r  <= '0;
      scan_dv_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      b_state_r   <= b_state_nxt;
      win_head_r  <= win_head_nxt;
      win_fill_r  <= win_fill_nxt;
      sum_r       <= sum_nxt;
      peak_r      <= peak_nxt;
      scnt_r      <= scnt_nxt;
      total_r     <= total_nxt;
      avg_r       <= avg_nxt;
      scan_idx_r  <= scan_idx_nxt;
      scan_dv_r   <= scan_dv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    scan_max_r <= scan_max_nxt;
    if (out_load) begin
      out_lat_r       <= item_r.lat;
      out_lat_valid_r <= item_r.lat_valid;
      out_avg_r       <= avg_r;
      out_max_r       <= peak_r;
      out_scnt_r      <= scnt_r;
      out_total_r     <= total_r;
      out_ovf_r       <= item_r.ovf;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_latency         = out_lat_r;
  assign out_latency_valid   = out_lat_valid_r;
  assign out_average_latency = out_avg_r;
  assign out_max_latency     = out_max_r;
  assign out_window_samples  = out_scnt_r;
  assign out_total_acks      = out_total_r;
  assign out_queue_overflow  = out_ovf_r;

endmodule

>>> rtl/latency_window_monitor.sv
// Top level of the request/ack latency monitor: front end, item queue, back end.
// Usage:
//   Input channel (in_valid / in_stall): one event per item, in_cmd is send,
//   ack or disconnect, in_now_ms the millisecond timestamp of the event.
//   Result channel (out_valid / out_stall): exactly one result item per input
//   item, in input order, carrying the measured latency and the window status.
// Path of an item, with an idle back end: every item passes the queue and the
//   back end's result state; an ack also waits for the serial divider that
//   forms the average. A matched ack first takes a front state, F_POP, for the
//   pending RAM read, with in_stall high meanwhile. A full window adds an
//   eviction step; evicting the maximum adds a rescan of the whole window.
//   A four-entry queue lets the front end accept events while the back end
//   is still busy.
// Reset: synchronous, active low; pending FIFO, window, counters and the
//   result register are emptied. RAM contents are not cleared.
// Stall: a stalled result holds in the output register; the back end stops
//   once it has its next result ready, the queue fills, then in_stall rises.
module latency_window_monitor (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [lwm_pkg::CMD_W-1:0] in_cmd,
  input  logic [lwm_pkg::TS_W-1:0]  in_now_ms,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [lwm_pkg::LAT_W-1:0] out_latency,
  output logic                      out_latency_valid,
  output logic [lwm_pkg::LAT_W-1:0] out_average_latency,
  output logic [lwm_pkg::LAT_W-1:0] out_max_latency,
  output logic [lwm_pkg::CNT_W-1:0] out_window_samples,
  output logic [lwm_pkg::TOT_W-1:0] out_total_acks,
  output logic                      out_queue_overflow
);
  import lwm_pkg::*;

  // front -> queue
  logic    q_push;
  q_item_t push_item;
  // queue -> back
  logic    q_pop;
  q_item_t pop_item;
  q_stat_t q_stat;

  // Front: pending request FIFO, overflow flag, latency measurement
  lwm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_cmd    (in_cmd),
    .in_now_ms (in_now_ms),
    .q_stat    (q_stat),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  lwm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .pop       (q_pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back: sample counters, window sum and peak, average, result register
  lwm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_stat              (q_stat),
    .q_item              (pop_item),
    .q_pop               (q_pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_latency         (out_latency),
    .out_latency_valid   (out_latency_valid),
    .out_average_latency (out_average_latency),
    .out_max_latency     (out_max_latency),
    .out_window_samples  (out_window_samples),
    .out_total_acks      (out_total_acks),
    .out_queue_overflow  (out_queue_overflow)
  );

  // front must never push into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("item pushed into full queue");

  // back must never pop an empty queue
  a_pop_data: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("item popped from empty queue");

  // a matched ack is never also a dropped send
  a_lat_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_latency_valid) |-> !out_queue_overflow)
    else $error("result flags both latency and overflow");

  // an unmatched result reports zero latency
  a_lat_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_latency_valid) |-> (out_latency == '0))
    else $error("nonzero latency without a match");

endmodule
